// File: hdl/pa_pkg.sv
package pa_pkg;

  // Default width of a vertex index
  localparam int INDEX_BITS_DEF = 24;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRIM_MODE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_BASE = 2'd1;

  // Primitive modes; code seven is unused
  typedef enum logic [2:0] {
    MODE_TRIANGLES  = 3'd0,
    MODE_QUADS      = 3'd1,
    MODE_FAN        = 3'd2,
    MODE_STRIP      = 3'd3,
    MODE_LINES      = 3'd4,
    MODE_LINE_STRIP = 3'd5,
    MODE_POINTS     = 3'd6
  } prim_mode_t;

  // Primitive kinds on the result channel
  localparam logic [1:0] KIND_TRIANGLE = 2'd0;
  localparam logic [1:0] KIND_LINE     = 2'd1;
  localparam logic [1:0] KIND_POINT    = 2'd2;

endpackage

// File: hdl/pa_ifs.sv
interface pa_vtx_if import pa_pkg::*; #(
  parameter int IndexBits = INDEX_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [IndexBits-1:0] vertex_index;
  logic                 first_of_draw;

  modport source (output valid, vertex_index, first_of_draw, input ready);
  modport sink   (input valid, vertex_index, first_of_draw, output ready);
endinterface

interface pa_prim_if import pa_pkg::*; #(
  parameter int IndexBits = INDEX_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           prim_kind;
  logic [IndexBits-1:0] corner_a;
  logic [IndexBits-1:0] corner_b;
  logic [IndexBits-1:0] corner_c;
  logic [IndexBits-1:0] max_seen;
  logic                 run_end;

  modport source (output valid, prim_kind, corner_a, corner_b, corner_c, max_seen, run_end,
                  input ready);
  modport sink   (input valid, prim_kind, corner_a, corner_b, corner_c, max_seen, run_end,
                  output ready);
endinterface

interface pa_cfg_if import pa_pkg::*; #(
  parameter int IndexBits = INDEX_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] reg_index;
  logic [IndexBits-1:0]      reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// File: hdl/primitive_assembler_unit.sv
// Primitive assembler: turns a stream of vertex indices into triangles,
// lines or points according to the prim_mode register.
// Channels: in_ch takes one vertex word (vertex_index, first_of_draw),
// out_ch gives one primitive word, cfg_ch writes prim_mode (index 0)
// and index_base (index 1); cfg_ch is always ready.
// Latency: the first primitive completed by a vertex appears on out_ch in the
// cycle after that vertex is accepted. Vertices that complete nothing
// only update the held corners and the running maximum.
// Throughput: one vertex per cycle while out_ch accepts, in every mode
// but quads; a vertex that completes a quad yields two words and holds
// in_ch while the second word sits in the spare register.
// Reset: mode goes to triangles, base to zero, assembly state and the
// running maximum clear, and both output registers empty.
// Stall: a word waiting on out_ch holds; in_ch drops ready while that word
// waits unaccepted or while the spare register is occupied; with it empty,
// a vertex is still taken in the cycle the output word leaves.
module primitive_assembler_unit import pa_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pa_vtx_if.sink     in_ch,
  pa_prim_if.source  out_ch,
  pa_cfg_if.sink     cfg_ch
);

  typedef logic [INDEX_BITS-1:0] idx_t;

  typedef struct packed {
    logic [1:0] kind;
    idx_t       a;
    idx_t       b;
    idx_t       c;
    idx_t       max;
    logic       run_end;
  } res_t;

  // configuration
  prim_mode_t mode_r;
  idx_t       base_r;

  // assembly state
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] seen_r, seen_nxt;
  idx_t       anchor_r, anchor_nxt;
  idx_t       older_r, older_nxt;
  idx_t       newer_r, newer_nxt;
  idx_t       max_r, max_nxt;

  // output side
  res_t       out_r, out_nxt;
  res_t       spare_r, spare_nxt;
  logic       out_v_r, out_v_nxt;
  logic       spare_v_r, spare_v_nxt;

  logic       acc;
  logic       pop;
  logic [INDEX_BITS:0] sum;
  idx_t       v;
  logic [1:0] phase_cur, seen_cur;
  idx_t       anchor_cur, older_cur, newer_cur, max_cur;
  res_t       res0, res1;
  logic       have0, have1;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !spare_v_r && (!out_v_r || out_ch.ready);
  assign acc          = in_ch.valid && in_ch.ready;
  assign pop          = out_v_r && out_ch.ready;

  assign out_ch.valid     = out_v_r;
  assign out_ch.prim_kind = out_r.kind;
  assign out_ch.corner_a  = out_r.a;
  assign out_ch.corner_b  = out_r.b;
  assign out_ch.corner_c  = out_r.c;
  assign out_ch.max_seen  = out_r.max;
  assign out_ch.run_end   = out_r.run_end;

  // saturating offset add
  assign sum = {1'b0, in_ch.vertex_index} + {1'b0, base_r};
  assign v   = sum[INDEX_BITS] ? '1 : sum[INDEX_BITS-1:0];

  // a new draw sees cleared state
  assign phase_cur  = in_ch.first_of_draw ? 2'd0 : phase_r;
  assign seen_cur   = in_ch.first_of_draw ? 2'd0 : seen_r;
  assign anchor_cur = in_ch.first_of_draw ? '0 : anchor_r;
  assign older_cur  = in_ch.first_of_draw ? '0 : older_r;
  assign newer_cur  = in_ch.first_of_draw ? '0 : newer_r;
  assign max_cur    = in_ch.first_of_draw ? '0 : max_r;

  always_comb begin
    phase_nxt  = phase_cur;
    seen_nxt   = seen_cur;
    anchor_nxt = anchor_cur;
    older_nxt  = older_cur;
    newer_nxt  = newer_cur;
    max_nxt    = (v > max_cur) ? v : max_cur;
    have0      = 1'b0;
    have1      = 1'b0;
    res0       = '{kind: KIND_TRIANGLE, a: '0, b: '0, c: '0, max: max_nxt, run_end: 1'b1};
    res1       = res0;

    unique case (mode_r)
      MODE_TRIANGLES: begin
        if (phase_cur == 2'd0) begin
          anchor_nxt = v;
          phase_nxt  = 2'd1;
        end else if (phase_cur == 2'd1) begin
          older_nxt = v;
          phase_nxt = 2'd2;
        end else begin
          res0.a    = anchor_cur;
          res0.b    = older_cur;
          res0.c    = v;
          have0     = 1'b1;
          phase_nxt = 2'd0;
        end
      end
      MODE_QUADS: begin
        if (phase_cur == 2'd0) begin
          anchor_nxt = v;
          phase_nxt  = 2'd1;
        end else if (phase_cur == 2'd1) begin
          older_nxt = v;
          phase_nxt = 2'd2;
        end else if (phase_cur == 2'd2) begin
          newer_nxt = v;
          phase_nxt = 2'd3;
        end else begin
          res0.a       = anchor_cur;
          res0.b       = older_cur;
          res0.c       = newer_cur;
          res0.run_end = 1'b0;
          res1.a       = anchor_cur;
          res1.b       = newer_cur;
          res1.c       = v;
          have0        = 1'b1;
          have1        = 1'b1;
          phase_nxt    = 2'd0;
        end
      end
      MODE_FAN: begin
        if (seen_cur == 2'd0) begin
          anchor_nxt = v;
          seen_nxt   = 2'd1;
        end else if (seen_cur == 2'd1) begin
          newer_nxt = v;
          seen_nxt  = 2'd2;
        end else begin
          res0.a    = anchor_cur;
          res0.b    = newer_cur;
          res0.c    = v;
          have0     = 1'b1;
          newer_nxt = v;
          seen_nxt  = 2'd2;
        end
      end
      MODE_STRIP: begin
        if (seen_cur == 2'd0) begin
          older_nxt = v;
          seen_nxt  = 2'd1;
        end else if (seen_cur == 2'd1) begin
          newer_nxt = v;
          seen_nxt  = 2'd2;
        end else begin
          res0.a    = older_cur;
          res0.b    = newer_cur;
          res0.c    = v;
          have0     = 1'b1;
          older_nxt = newer_cur;
          newer_nxt = v;
          seen_nxt  = 2'd2;
        end
      end
      MODE_LINES: begin
        if (phase_cur == 2'd0) begin
          anchor_nxt = v;
          phase_nxt  = 2'd1;
        end else begin
          res0.kind = KIND_LINE;
          res0.a    = anchor_cur;
          res0.b    = v;
          have0     = 1'b1;
          phase_nxt = 2'd0;
        end
      end
      MODE_LINE_STRIP: begin
        if (seen_cur == 2'd0) begin
          newer_nxt = v;
          seen_nxt  = 2'd1;
        end else begin
          res0.kind = KIND_LINE;
          res0.a    = newer_cur;
          res0.b    = v;
          have0     = 1'b1;
          newer_nxt = v;
          seen_nxt  = 2'd1;
        end
      end
      MODE_POINTS: begin
        res0.kind = KIND_POINT;
        res0.a    = v;
        have0     = 1'b1;
      end
      default: begin
        // unused mode: only the running maximum moves
      end
    endcase
  end

  always_comb begin
    out_nxt     = out_r;
    spare_nxt   = spare_r;
    out_v_nxt   = out_v_r;
    spare_v_nxt = spare_v_r;
    if (pop) begin
      if (spare_v_r) begin
        out_nxt     = spare_r;
        spare_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
    if (acc && have0) begin
      out_nxt   = res0;
      out_v_nxt = 1'b1;
    end
    if (acc && have1) begin
      spare_nxt   = res1;
      spare_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_TRIANGLES;
      base_r    <= '0;
      phase_r   <= 2'd0;
      seen_r    <= 2'd0;
      anchor_r  <= '0;
      older_r   <= '0;
      newer_r   <= '0;
      max_r     <= '0;
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.reg_index == REG_PRIM_MODE) begin
          mode_r <= prim_mode_t'(cfg_ch.reg_data[2:0]);
        end else if (cfg_ch.reg_index == REG_INDEX_BASE) begin
          base_r <= cfg_ch.reg_data[INDEX_BITS-1:0];
        end
      end
      if (acc) begin
        phase_r  <= phase_nxt;
        seen_r   <= seen_nxt;
        anchor_r <= anchor_nxt;
        older_r  <= older_nxt;
        newer_r  <= newer_nxt;
        max_r    <= max_nxt;
      end
      out_v_r   <= out_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    spare_r <= spare_nxt;
  end

  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_v_r)
    else $error("spare word held without an output word");

  a_spare_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> !in_ch.ready)
    else $error("input taken while spare word pending");

  a_quad_two_words: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && mode_r == MODE_QUADS && phase_cur == 2'd3) |=> (out_v_r && spare_v_r))
    else $error("completed quad did not yield two words");

  a_corners_within_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.a <= out_r.max && out_r.b <= out_r.max && out_r.c <= out_r.max))
    else $error("corner above running maximum");

endmodule
